FILE: hdl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// shared types, address map constants and command codes of the memory map
// ----------------------------------------------------------------------------
package bsm_pkg;

    // port bank bits
    localparam logic [7:0] LORAM_BIT  = 8'h01;
    localparam logic [7:0] HIRAM_BIT  = 8'h02;
    localparam logic [7:0] CHAREN_BIT = 8'h04;

    // address map
    localparam logic [15:0] ADDR_DDR      = 16'h0000;
    localparam logic [15:0] ADDR_PORT     = 16'h0001;
    localparam logic [15:0] ADDR_ROM_A_LO = 16'hA000;
    localparam logic [15:0] ADDR_ROM_A_HI = 16'hBFFF;
    localparam logic [15:0] ADDR_IO_LO    = 16'hD000;
    localparam logic [15:0] ADDR_IO_HI    = 16'hDFFF;
    localparam logic [15:0] ADDR_VID_HI   = 16'hD3FF;
    localparam logic [15:0] ADDR_COL_LO   = 16'hD800;
    localparam logic [15:0] ADDR_COL_HI   = 16'hDBFF;
    localparam logic [15:0] ADDR_ROM_E_LO = 16'hE000;
    localparam logic [5:0]  VID_REG_MASK  = 6'h3F;
    localparam logic [3:0]  COL_MASK      = 4'hF;

    // store address widths
    localparam int RAM_AW   = 16;
    localparam int ROMA_AW  = 13;
    localparam int ROME_AW  = 13;
    localparam int GLYPH_AW = 12;
    localparam int COL_AW   = 10;
    localparam int COL_DW   = 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // func codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    // video access codes
    localparam logic [1:0] VACC_NONE  = 2'd0;
    localparam logic [1:0] VACC_READ  = 2'd1;
    localparam logic [1:0] VACC_WRITE = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  write_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] video_access;
        logic [5:0] video_reg;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_CONST,
        OP_RAM_RD,
        OP_RAM_WR,
        OP_ROMA_RD,
        OP_ROMA_WR,
        OP_ROME_RD,
        OP_ROME_WR,
        OP_GLYPH_RD,
        OP_GLYPH_WR,
        OP_COL_RD,
        OP_COL_WR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  rdata;
        logic [1:0]  vacc;
        logic [5:0]  vreg;
    } cmd_t;

endpackage

FILE: hdl/bsm_front.sv
// ----------------------------------------------------------------------------
// bsm_front
// holds the port registers and classifies each accepted item into a command
// ----------------------------------------------------------------------------
module bsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bsm_pkg::in_item_t item,
    output bsm_pkg::cmd_t     cmd
);

    logic [7:0] ddr_reg, ddr_next;
    logic [7:0] latch_reg, latch_next;
    logic [7:0] eff_port;
    logic       lo, hi, charen;
    logic       in_rom_a, in_io, in_rom_e, in_vid, in_col;

    assign eff_port = (latch_reg & ddr_reg) | ~ddr_reg;
    assign lo       = (eff_port & bsm_pkg::LORAM_BIT) != 8'h00;
    assign hi       = (eff_port & bsm_pkg::HIRAM_BIT) != 8'h00;
    assign charen   = (eff_port & bsm_pkg::CHAREN_BIT) != 8'h00;

    assign in_rom_a = item.addr >= bsm_pkg::ADDR_ROM_A_LO && item.addr <= bsm_pkg::ADDR_ROM_A_HI;
    assign in_io    = item.addr >= bsm_pkg::ADDR_IO_LO && item.addr <= bsm_pkg::ADDR_IO_HI;
    assign in_rom_e = item.addr >= bsm_pkg::ADDR_ROM_E_LO;
    assign in_vid   = in_io && item.addr <= bsm_pkg::ADDR_VID_HI;
    assign in_col   = item.addr >= bsm_pkg::ADDR_COL_LO && item.addr <= bsm_pkg::ADDR_COL_HI;

    always_comb
    begin
        cmd       = '0;
        cmd.op    = bsm_pkg::OP_CONST;
        cmd.addr  = item.addr;
        cmd.wdata = item.write_data;
        priority if (item.func == bsm_pkg::FUNC_READ)
        begin
            priority if (item.addr == bsm_pkg::ADDR_DDR)
                cmd.rdata = ddr_reg;
            else if (item.addr == bsm_pkg::ADDR_PORT)
                cmd.rdata = eff_port;
            else if (in_rom_a)
                cmd.op = (lo && hi) ? bsm_pkg::OP_ROMA_RD : bsm_pkg::OP_RAM_RD;
            else if (in_io)
            begin
                priority if (!lo && !hi)
                    cmd.op = bsm_pkg::OP_RAM_RD;
                else if (!charen)
                    cmd.op = bsm_pkg::OP_GLYPH_RD;
                else if (in_vid)
                begin
                    cmd.vacc = bsm_pkg::VACC_READ;
                    cmd.vreg = item.addr[5:0] & bsm_pkg::VID_REG_MASK;
                end
                else if (in_col)
                    cmd.op = bsm_pkg::OP_COL_RD;
                else
                    cmd.op = bsm_pkg::OP_CONST;
            end
            else if (in_rom_e)
                cmd.op = hi ? bsm_pkg::OP_ROME_RD : bsm_pkg::OP_RAM_RD;
            else
                cmd.op = bsm_pkg::OP_RAM_RD;
        end
        else if (item.func == bsm_pkg::FUNC_WRITE)
        begin
            priority if (item.addr == bsm_pkg::ADDR_DDR || item.addr == bsm_pkg::ADDR_PORT)
                cmd.op = bsm_pkg::OP_CONST;
            else if (in_io && (lo || hi) && charen)
            begin
                priority if (in_vid)
                begin
                    cmd.vacc = bsm_pkg::VACC_WRITE;
                    cmd.vreg = item.addr[5:0] & bsm_pkg::VID_REG_MASK;
                end
                else if (in_col)
                    cmd.op = bsm_pkg::OP_COL_WR;
                else
                    cmd.op = bsm_pkg::OP_CONST;
            end
            else
                cmd.op = bsm_pkg::OP_RAM_WR;
        end
        else if (item.func == bsm_pkg::FUNC_LOAD)
        begin
            priority if (in_rom_a)
                cmd.op = bsm_pkg::OP_ROMA_WR;
            else if (in_io)
                cmd.op = bsm_pkg::OP_GLYPH_WR;
            else if (in_rom_e)
                cmd.op = bsm_pkg::OP_ROME_WR;
            else
                cmd.op = bsm_pkg::OP_CONST;
        end
        else
            cmd.op = bsm_pkg::OP_CONST;
    end

    // port registers change at accept so the next item sees the new map
    always_comb
    begin
        ddr_next   = ddr_reg;
        latch_next = latch_reg;
        if (accept && item.func == bsm_pkg::FUNC_WRITE)
        begin
            if (item.addr == bsm_pkg::ADDR_DDR)
                ddr_next = item.write_data;
            if (item.addr == bsm_pkg::ADDR_PORT)
                latch_next = item.write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ddr_reg   <= '0;
            latch_reg <= '0;
        end
        else
        begin
            ddr_reg   <= ddr_next;
            latch_reg <= latch_next;
        end
    end

endmodule

FILE: hdl/bsm_queue.sv
// ----------------------------------------------------------------------------
// bsm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module bsm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bsm_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bsm_pkg::cmd_t pop_cmd,
    output logic          empty,
    output logic          full
);

    bsm_pkg::cmd_t                 slot_reg [bsm_pkg::QUEUE_DEPTH];
    logic [bsm_pkg::QUEUE_PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bsm_pkg::QUEUE_PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bsm_pkg::QUEUE_CW-1:0]  count_reg, count_next;
    logic                          do_push, do_pop;

    assign empty   = count_reg == '0;
    assign full    = count_reg == bsm_pkg::QUEUE_CW'(bsm_pkg::QUEUE_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    function automatic logic [bsm_pkg::QUEUE_PW-1:0] ptr_inc(
        input logic [bsm_pkg::QUEUE_PW-1:0] p
    );
        ptr_inc = (p == bsm_pkg::QUEUE_PW'(bsm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

FILE: hdl/bsm_back.sv
// ----------------------------------------------------------------------------
// bsm_back
// carries out commands on the stores and forms the result item
// ----------------------------------------------------------------------------
module bsm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  bsm_pkg::cmd_t      cmd,
    output logic               strobe,
    output bsm_pkg::out_item_t result
);

    logic [7:0]                 main_ram   [2**bsm_pkg::RAM_AW];
    logic [7:0]                 rom_a_mem  [2**bsm_pkg::ROMA_AW];
    logic [7:0]                 rom_e_mem  [2**bsm_pkg::ROME_AW];
    logic [7:0]                 glyph_mem  [2**bsm_pkg::GLYPH_AW];
    logic [bsm_pkg::COL_DW-1:0] col_mem    [2**bsm_pkg::COL_AW];

    logic [7:0]                 ram_rd_reg, rom_a_rd_reg, rom_e_rd_reg, glyph_rd_reg;
    logic [bsm_pkg::COL_DW-1:0] col_rd_reg;
    logic                       valid_reg, valid_next;
    bsm_pkg::op_t               op_reg;
    logic [7:0]                 rdata_reg;
    logic [1:0]                 vacc_reg;
    logic [5:0]                 vreg_reg;

    logic [bsm_pkg::RAM_AW-1:0]   ram_a;
    logic [bsm_pkg::ROMA_AW-1:0]  rom_a_a;
    logic [bsm_pkg::ROME_AW-1:0]  rom_e_a;
    logic [bsm_pkg::GLYPH_AW-1:0] glyph_a;
    logic [bsm_pkg::COL_AW-1:0]   col_a;

    assign ram_a   = cmd.addr[bsm_pkg::RAM_AW-1:0];
    assign rom_a_a = cmd.addr[bsm_pkg::ROMA_AW-1:0];
    assign rom_e_a = cmd.addr[bsm_pkg::ROME_AW-1:0];
    assign glyph_a = cmd.addr[bsm_pkg::GLYPH_AW-1:0];
    assign col_a   = cmd.addr[bsm_pkg::COL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (cmd.op == bsm_pkg::OP_RAM_WR)
                main_ram[ram_a] <= cmd.wdata;
            ram_rd_reg <= main_ram[ram_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (cmd.op == bsm_pkg::OP_ROMA_WR)
                rom_a_mem[rom_a_a] <= cmd.wdata;
            rom_a_rd_reg <= rom_a_mem[rom_a_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (cmd.op == bsm_pkg::OP_ROME_WR)
                rom_e_mem[rom_e_a] <= cmd.wdata;
            rom_e_rd_reg <= rom_e_mem[rom_e_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (cmd.op == bsm_pkg::OP_GLYPH_WR)
                glyph_mem[glyph_a] <= cmd.wdata;
            glyph_rd_reg <= glyph_mem[glyph_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (cmd.op == bsm_pkg::OP_COL_WR)
                col_mem[col_a] <= cmd.wdata[bsm_pkg::COL_DW-1:0] & bsm_pkg::COL_MASK;
            col_rd_reg <= col_mem[col_a];
        end
    end

    assign valid_next = cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            op_reg    <= cmd.op;
            rdata_reg <= cmd.rdata;
            vacc_reg  <= cmd.vacc;
            vreg_reg  <= cmd.vreg;
        end
    end

    assign strobe              = valid_reg;
    assign result.video_access = vacc_reg;
    assign result.video_reg    = vreg_reg;

    always_comb
    begin
        unique case (op_reg)
            bsm_pkg::OP_CONST:    result.read_data = rdata_reg;
            bsm_pkg::OP_RAM_RD:   result.read_data = ram_rd_reg;
            bsm_pkg::OP_ROMA_RD:  result.read_data = rom_a_rd_reg;
            bsm_pkg::OP_ROME_RD:  result.read_data = rom_e_rd_reg;
            bsm_pkg::OP_GLYPH_RD: result.read_data = glyph_rd_reg;
            bsm_pkg::OP_COL_RD:   result.read_data = {4'h0, col_rd_reg & bsm_pkg::COL_MASK};
            default:              result.read_data = 8'h00;
        endcase
    end

endmodule

FILE: hdl/bank_switched_memory_map.sv
// ----------------------------------------------------------------------------
// bank_switched_memory_map
// bank-switched memory map: ram, three roms, color store and port registers
// ----------------------------------------------------------------------------
// usage
//   - input channel: drive item and raise start; the item is taken at a
//     rising edge with start high and busy low
//   - item.func selects cpu read, cpu write or rom byte load
//   - output channel: every item gives one result, shown on result for
//     exactly one cycle with strobe high; the receiver cannot stall
//   - a taken item is written into a queue slot, then popped into the
//     back end's registered store read, which drives result and strobe
//   - throughput: one item per cycle; the back end drains the queue every
//     cycle, so busy only rises if the two-entry queue fills
//   - the port registers live in the front and change as the item is taken,
//     so the following item already decodes with the new bank bits
//   - reset clears the port registers, the queue and the strobe; the
//     stores are not cleared and must be written before they are read
//   - video chip accesses are not performed, only flagged with an index
// ----------------------------------------------------------------------------
module bank_switched_memory_map (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bsm_pkg::in_item_t  item,
    output logic               strobe,
    output bsm_pkg::out_item_t result
);

    logic          accept;
    logic          q_empty, q_full;
    bsm_pkg::cmd_t front_cmd;
    bsm_pkg::cmd_t back_cmd;
    logic          back_valid;

    // queue full holds off new items
    assign busy   = q_full;
    assign accept = start && !busy;

    // front: port registers and address decode
    bsm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (front_cmd)
    );

    // decoupling queue
    bsm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (back_valid),
        .pop_cmd  (back_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // back is always ready, so any queued command is taken at once
    assign back_valid = !q_empty;

    // back: stores and result formatting
    bsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

FILE: hdl/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// port level checks of the memory map, bound to the top level
// ----------------------------------------------------------------------------
module bsm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input bsm_pkg::in_item_t  item,
    input logic               strobe,
    input bsm_pkg::out_item_t result
);

    // every taken item gives its result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 strobe)
        else $error("result missing two cycles after item");

    // no result without an item taken before it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(start && !busy && rst_n, 2))
        else $error("result without item");

    // writes and loads return zero data
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.func != bsm_pkg::FUNC_READ |-> ##2 result.read_data == 8'h00)
        else $error("nonzero data on write or load");

    // register index only on a video access
    a_vreg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.video_access == bsm_pkg::VACC_NONE |-> result.video_reg == 6'h00)
        else $error("video index without video access");

endmodule

bind bank_switched_memory_map bsm_checker u_bsm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);
